@@ hdl/rc4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, codes and types of the RC4 engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int SBOX_DEPTH    = 256;
  localparam int SBOX_AW       = 8;
  localparam int KEY_DEPTH_DEF = 256;

  // req_type codes
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // out_kind codes
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D_RD_J,
    ST_D_SWAP_I,
    ST_D_SWAP_J,
    ST_K_RD_N,
    ST_K_ADD,
    ST_K_SWAP_N,
    ST_K_SWAP_J,
    ST_OUT
  } rc4_state_t;

  // Access request to the permutation store
  typedef struct packed {
    logic [SBOX_AW-1:0] rd_addr;
    logic               wr_en;
    logic [SBOX_AW-1:0] wr_addr;
    logic [BYTE_W-1:0]  wr_data;
    logic               clear;   // back to identity
  } perm_req_t;

endpackage

@@ hdl/rc4_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_if
// Valid/ready channels of the RC4 engine: input items and result items.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] in_byte;
  logic              last_key;

  modport source (output valid, output req_type, output in_byte, output last_key,
                  input ready);
  modport sink   (input valid, input req_type, input in_byte, input last_key,
                  output ready);
endinterface

interface rc4_out_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [BYTE_W-1:0] keystream_byte;
  logic              out_kind;
  logic              key_clipped;

  modport source (output valid, output out_byte, output keystream_byte,
                  output out_kind, output key_clipped, input ready);
  modport sink   (input valid, input out_byte, input keystream_byte,
                  input out_kind, input key_clipped, output ready);
endinterface

@@ hdl/rc4_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/rc4_perm_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_perm_mem
// Permutation store: 256 x 8 RAM plus one valid bit per entry. An entry
// not written since the last clear reads as its own index (identity).
// ----------------------------------------------------------------------------
module rc4_perm_mem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rc4_pkg::perm_req_t                req,
  output logic [rc4_pkg::BYTE_W-1:0]        rd_data
);
  import rc4_pkg::*;

  logic [SBOX_DEPTH-1:0] vld_r;
  logic                  rd_vld_r;
  logic [SBOX_AW-1:0]    rd_addr_r;
  logic [BYTE_W-1:0]     ram_rd;

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH),
    .AW    (SBOX_AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_addr (req.rd_addr),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // old valid bit, consistent with read-old RAM behavior
  always_ff @(posedge clk) begin
    rd_vld_r  <= vld_r[req.rd_addr];
    rd_addr_r <= req.rd_addr;
  end

  assign rd_data = rd_vld_r ? ram_rd : rd_addr_r;

endmodule

@@ hdl/rc4_stream_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 engine: key load, 256-step key schedule and keystream XOR of data.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | handshake
//  in_ch    | in  | req_type, in_byte, last_key                  | valid/ready
//  out_ch   | out | out_byte, keystream_byte, out_kind, key_clipped | valid/ready
//
//  Data item: read-j, swap-i and swap-j steps plus the output load from accept
//    to next accept; forced by the single read port of the permutation RAM.
//  Key item, not last: stored, no result; the engine stays ready.
//  Last key item: 256 schedule steps of read, add and two swap states each.
//  Reset: synchronous, active low; permutation reads as identity through
//    per-entry valid bits, no clearing pass.
//  Output register: one result may wait on out_ch while the next item is
//    taken; the sequencer holds in its output step until that slot frees.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rc4_in_if.sink    in_ch,
  rc4_out_if.source out_ch
);
  import rc4_pkg::*;

  localparam int KA_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int CNT_W = $clog2(KEY_DEPTH + 1);

  // sequencer and control state
  rc4_state_t         state_r, state_nxt;
  logic [SBOX_AW-1:0] i_r, i_nxt;       // keystream i, schedule step n
  logic [SBOX_AW-1:0] j_r, j_nxt;
  logic [CNT_W-1:0]   key_cnt_r, key_cnt_nxt;
  logic [KA_W-1:0]    kidx_r, kidx_nxt;
  logic               loading_r, loading_nxt;
  logic               clip_r, clip_nxt;
  logic               out_valid_r, out_valid_nxt;

  // datapath registers
  logic [BYTE_W-1:0]  si_r, si_nxt;
  logic [BYTE_W-1:0]  sj_r, sj_nxt;
  logic [SBOX_AW-1:0] t_r, t_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [BYTE_W-1:0]  res_ks_r, res_ks_nxt;
  logic               res_kind_r, res_kind_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic [BYTE_W-1:0]  out_ks_r, out_ks_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic               out_clip_r, out_clip_nxt;

  // memory ports
  perm_req_t          perm_req;
  logic [BYTE_W-1:0]  prd;
  logic               key_wr_en;
  logic [KA_W-1:0]    key_wr_addr;
  logic [BYTE_W-1:0]  krd;

  // misc
  logic               in_fire;
  logic               out_free;
  logic [CNT_W-1:0]   cnt_base;
  logic               kidx_wrap;

  rc4_perm_mem u_perm (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (perm_req),
    .rd_data (prd)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_DEPTH),
    .AW    (KA_W)
  ) u_key (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (in_ch.in_byte),
    .rd_addr (kidx_r),
    .rd_data (krd)
  );

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign cnt_base      = loading_r ? key_cnt_r : '0;
  assign kidx_wrap     = (CNT_W'(kidx_r) + CNT_W'(1)) >= key_cnt_r;

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    key_cnt_nxt  = key_cnt_r;
    kidx_nxt     = kidx_r;
    loading_nxt  = loading_r;
    clip_nxt     = clip_r;
    si_nxt       = si_r;
    sj_nxt       = sj_r;
    t_nxt        = t_r;
    byte_nxt     = byte_r;
    res_ks_nxt   = res_ks_r;
    res_kind_nxt = res_kind_r;
    out_byte_nxt = out_byte_r;
    out_ks_nxt   = out_ks_r;
    out_kind_nxt = out_kind_r;
    out_clip_nxt = out_clip_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    perm_req         = '0;
    perm_req.rd_addr = i_r + SBOX_AW'(1);
    key_wr_en        = 1'b0;
    key_wr_addr      = cnt_base[KA_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.req_type == REQ_DATA) begin
            // read S[i+1] already on the port
            loading_nxt = 1'b0;
            i_nxt       = i_r + SBOX_AW'(1);
            byte_nxt    = in_ch.in_byte;
            state_nxt   = ST_D_RD_J;
          end else begin
            clip_nxt = loading_r ? clip_r : 1'b0;
            if (cnt_base < CNT_W'(KEY_DEPTH)) begin
              key_wr_en   = 1'b1;
              key_cnt_nxt = cnt_base + CNT_W'(1);
            end else begin
              key_cnt_nxt = cnt_base;
              clip_nxt    = 1'b1;
            end
            if (in_ch.last_key) begin
              loading_nxt    = 1'b0;
              perm_req.clear = 1'b1;
              i_nxt          = '0;
              j_nxt          = '0;
              kidx_nxt       = '0;
              state_nxt      = ST_K_RD_N;
            end else begin
              loading_nxt = 1'b1;
            end
          end
        end
      end

      // keystream step
      ST_D_RD_J: begin
        si_nxt           = prd;
        j_nxt            = j_r + prd;
        perm_req.rd_addr = j_r + prd;
        state_nxt        = ST_D_SWAP_I;
      end
      ST_D_SWAP_I: begin
        sj_nxt           = prd;
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = i_r;
        perm_req.wr_data = prd;
        t_nxt            = si_r + prd;
        perm_req.rd_addr = si_r + prd;   // old S[t]
        state_nxt        = ST_D_SWAP_J;
      end
      ST_D_SWAP_J: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = j_r;
        perm_req.wr_data = si_r;
        // forward the swapped entries over the old read
        if (t_r == j_r) begin
          res_ks_nxt = si_r;
        end else if (t_r == i_r) begin
          res_ks_nxt = sj_r;
        end else begin
          res_ks_nxt = prd;
        end
        res_kind_nxt = KIND_DATA;
        state_nxt    = ST_OUT;
      end

      // key schedule step n = i_r
      ST_K_RD_N: begin
        perm_req.rd_addr = i_r;
        state_nxt        = ST_K_ADD;
      end
      ST_K_ADD: begin
        si_nxt           = prd;
        j_nxt            = j_r + prd + krd;
        perm_req.rd_addr = j_r + prd + krd;
        state_nxt        = ST_K_SWAP_N;
      end
      ST_K_SWAP_N: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = i_r;
        perm_req.wr_data = prd;
        state_nxt        = ST_K_SWAP_J;
      end
      ST_K_SWAP_J: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = j_r;
        perm_req.wr_data = si_r;
        i_nxt            = i_r + SBOX_AW'(1);
        kidx_nxt         = kidx_wrap ? '0 : kidx_r + KA_W'(1);
        if (i_r == SBOX_AW'(SBOX_DEPTH - 1)) begin
          j_nxt        = '0;
          byte_nxt     = '0;
          res_ks_nxt   = '0;
          res_kind_nxt = KIND_DONE;
          state_nxt    = ST_OUT;
        end else begin
          state_nxt = ST_K_RD_N;
        end
      end

      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r ^ res_ks_r;
          out_ks_nxt    = res_ks_r;
          out_kind_nxt  = res_kind_r;
          out_clip_nxt  = (res_kind_r == KIND_DONE) ? clip_r : 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      key_cnt_r   <= '0;
      kidx_r      <= '0;
      loading_r   <= 1'b0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      key_cnt_r   <= key_cnt_nxt;
      kidx_r      <= kidx_nxt;
      loading_r   <= loading_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    byte_r     <= byte_nxt;
    res_ks_r   <= res_ks_nxt;
    res_kind_r <= res_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_ks_r   <= out_ks_nxt;
    out_kind_r <= out_kind_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.keystream_byte = out_ks_r;
  assign out_ch.out_kind       = out_kind_r;
  assign out_ch.key_clipped    = out_clip_r;

`ifndef ASSERT_OFF
  // a new result only comes from the output step
  a_out_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside output step");

  // schedule leaves i and j at zero
  a_sched_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && res_kind_r == KIND_DONE) |-> (i_r == '0 && j_r == '0))
    else $error("schedule did not leave i and j at zero");

  // key count saturates at the store depth
  a_key_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_cnt_r <= CNT_W'(KEY_DEPTH))
    else $error("key count past store depth");

  // schedule reads only stored key bytes
  a_kidx_in_key: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_K_RD_N |-> CNT_W'(kidx_r) < key_cnt_r)
    else $error("key index past stored key length");

  // data results never carry the clip flag
  a_data_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_DATA) |-> !out_clip_r)
    else $error("clip flag on a data result");
`endif

endmodule

@@ tb/sv/rc4_stream_cipher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_tb
// Self-checking bench for the RC4 engine. A directed table covers reset-state
// keystream, single-byte, full-depth and clipped keys, loads abandoned by
// data and keys that follow a finished schedule. Random key/data sequences
// follow. Every result item is scored against a cycle-free RC4 predictor or
// a typed-in result, with both channels idling at random outside a no-idle stretch.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  localparam int KEY_DEPTH    = KEY_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1070;
  localparam int IDLE_PCT     = 11;
  // longest legal quiet spell is one key schedule plus stalls
  localparam int STALL_LIMIT  = 5000;
  // after the last result: a trailing key byte may still be in flight
  localparam int DRAIN_CYCLES = 1100;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [BYTE_W-1:0] ks_byte;
    logic              kind;
    logic              clipped;
  } rc4_result_t;

  // one directed row; reps > 1 repeats the row with an incrementing byte
  typedef struct {
    logic              req;
    logic [BYTE_W-1:0] value;
    logic              last;
    int                reps;
    bit                fixed;
    rc4_result_t       fixed_res;
  } stim_row_t;

  // per-item tag: a typed-in result replaces the predicted one
  typedef struct {
    bit          fixed;
    rc4_result_t res;
  } item_tag_t;

  localparam rc4_result_t NO_RESULT    = '0;
  localparam rc4_result_t DONE_PLAIN   = {8'h00, 8'h00, KIND_DONE, 1'b0};
  localparam rc4_result_t DONE_CLIPPED = {8'h00, 8'h00, KIND_DONE, 1'b1};

  logic clk;
  logic rst_n;
  logic no_idle;

  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();

  rc4_stream_cipher #(.KEY_DEPTH(KEY_DEPTH)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // --------------------------------------------------------------------------
  // Predictor state: permutation, key copy, generator indexes, load status
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] sbox_model [SBOX_DEPTH];
  logic [BYTE_W-1:0] key_copy   [KEY_DEPTH];
  logic [BYTE_W-1:0] gen_i, gen_j;
  int                key_cnt;
  bit                key_loading, key_dropped;

  rc4_result_t expected_results [$];
  item_tag_t   item_tags [$];
  stim_row_t   directed_rows [$];

  int mismatches, stored_items;
  int n_data, n_done, n_clipped, n_abandoned;

  // RC4 step for one accepted item; mirrors key load, schedule and PRGA
  task automatic rc4_predict(input logic req, input logic [BYTE_W-1:0] value,
                             input logic last, output bit has_res,
                             output rc4_result_t res);
    logic [BYTE_W-1:0] tmp, jj, sum;
    int                k, kidx, len;
    has_res = 1'b0;
    res     = NO_RESULT;
    if (req == REQ_DATA) begin
      // data abandons any partial load and runs on the current state
      if (key_loading) n_abandoned++;
      key_loading = 1'b0;
      gen_i = gen_i + 8'd1;
      gen_j = gen_j + sbox_model[gen_i];
      tmp                = sbox_model[gen_i];
      sbox_model[gen_i]  = sbox_model[gen_j];
      sbox_model[gen_j]  = tmp;
      sum     = sbox_model[gen_i] + sbox_model[gen_j];
      has_res = 1'b1;
      res     = {value ^ sbox_model[sum], sbox_model[sum], KIND_DATA, 1'b0};
    end else begin
      if (!key_loading) begin
        key_cnt     = 0;
        key_dropped = 1'b0;
        key_loading = 1'b1;
      end
      if (key_cnt < KEY_DEPTH) begin
        key_copy[key_cnt] = value;
        key_cnt++;
      end else begin
        key_dropped = 1'b1;
      end
      if (last) begin
        len = (key_cnt == 0 || key_cnt > KEY_DEPTH) ? 1 : key_cnt;
        for (k = 0; k < SBOX_DEPTH; k++) sbox_model[k] = k[BYTE_W-1:0];
        jj   = '0;
        kidx = 0;
        for (k = 0; k < SBOX_DEPTH; k++) begin
          jj = jj + sbox_model[k] + key_copy[kidx];
          tmp            = sbox_model[k];
          sbox_model[k]  = sbox_model[jj];
          sbox_model[jj] = tmp;
          kidx++;
          if (kidx >= len) kidx = 0;
        end
        gen_i       = '0;
        gen_j       = '0;
        key_loading = 1'b0;
        has_res     = 1'b1;
        res         = key_dropped ? DONE_CLIPPED : DONE_PLAIN;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, off during the no-idle stretch
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: score results first, then predict from the accepted input item.
  // A result can never belong to an item taken at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit          has_res;
    rc4_result_t pred, got, want;
    item_tag_t   tag;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_byte, out_ch.keystream_byte, out_ch.out_kind, out_ch.key_clipped};
        if (got.kind == KIND_DONE) begin
          n_done++;
          if (got.clipped) n_clipped++;
        end else begin
          n_data++;
        end
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", int'(got), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
          if (got.ks_byte !== want.ks_byte)
            report_mismatch("keystream_byte", int'(got.ks_byte), int'(want.ks_byte));
          if (got.kind !== want.kind)
            report_mismatch("out_kind", int'(got.kind), int'(want.kind));
          if (got.clipped !== want.clipped)
            report_mismatch("key_clipped", int'(got.clipped), int'(want.clipped));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        rc4_predict(in_ch.req_type, in_ch.in_byte, in_ch.last_key, has_res, pred);
        if (item_tags.size() != 0) begin
          tag = item_tags.pop_front();
        end else begin
          tag.fixed = 1'b0;
          tag.res   = NO_RESULT;
        end
        if (has_res)
          expected_results.insert(expected_results.size(), tag.fixed ? tag.res : pred);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any item moving on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int quiet_cycles;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("rc4_stream_cipher verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Drive one item and hold it until accepted. Random idle cycles come first,
  // with junk on the payload so the bus is not frozen while valid is low.
  task automatic send_item(input logic req, input logic [BYTE_W-1:0] value,
                           input logic last, input bit fixed,
                           input rc4_result_t fixed_res);
    item_tag_t tag;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid    <= 1'b0;
      in_ch.req_type <= 1'($urandom_range(1));
      in_ch.in_byte  <= BYTE_W'($urandom_range(255));
      in_ch.last_key <= 1'($urandom_range(1));
      @(posedge clk);
    end
    tag.fixed = fixed;
    tag.res   = fixed_res;
    item_tags.insert(item_tags.size(), tag);
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.in_byte  <= value;
    in_ch.last_key <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // random key of len bytes; last flag on the final byte only if with_last
  task automatic send_key(input int len, input bit with_last);
    int k;
    for (k = 0; k < len; k++) begin
      send_item(REQ_KEY, BYTE_W'($urandom_range(255)), with_last && (k == len - 1),
                1'b0, NO_RESULT);
      if (k < KEY_DEPTH) stored_items++;
    end
  endtask

  // data burst; last_key is random since data ignores it
  task automatic send_data(input int len);
    repeat (len) begin
      send_item(REQ_DATA, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                1'b0, NO_RESULT);
      stored_items++;
    end
  endtask

  task automatic add_row(input logic req, input logic [BYTE_W-1:0] value,
                         input logic last, input int reps, input bit fixed,
                         input rc4_result_t fixed_res);
    stim_row_t row;
    row.req       = req;
    row.value     = value;
    row.last      = last;
    row.reps      = reps;
    row.fixed     = fixed;
    row.fixed_res = fixed_res;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int r, k, pick, len;
    rst_n          = 1'b0;
    no_idle        = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_KEY;
    in_ch.in_byte  = '0;
    in_ch.last_key = 1'b0;
    for (k = 0; k < SBOX_DEPTH; k++) sbox_model[k] = k[BYTE_W-1:0];
    for (k = 0; k < KEY_DEPTH; k++) key_copy[k] = '0;
    gen_i       = '0;
    gen_j       = '0;
    key_cnt     = 0;
    key_loading = 1'b0;
    key_dropped = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Typed-in results only where obvious: the reset-state
    // keystream (identity permutation) and done/clipped answers.
    add_row(REQ_DATA, 8'h00, 1'b0, 1, 1'b1, {8'h02, 8'h02, KIND_DATA, 1'b0});
    add_row(REQ_DATA, 8'hFF, 1'b1, 1, 1'b1, {8'hFA, 8'h05, KIND_DATA, 1'b0});
    // key after data starts a load; data then abandons it
    add_row(REQ_KEY,  8'h00, 1'b0, 1, 1'b0, NO_RESULT);
    add_row(REQ_DATA, 8'h5A, 1'b0, 1, 1'b0, NO_RESULT);
    // single-byte key, max value
    add_row(REQ_KEY,  8'hFF, 1'b1, 1, 1'b1, DONE_PLAIN);
    add_row(REQ_DATA, 8'h00, 1'b0, 1, 1'b0, NO_RESULT);
    add_row(REQ_DATA, 8'hFF, 1'b1, 1, 1'b0, NO_RESULT);
    // textbook three-byte key followed by plaintext
    add_row(REQ_KEY,  8'h4B, 1'b0, 1, 1'b0, NO_RESULT);
    add_row(REQ_KEY,  8'h65, 1'b0, 1, 1'b0, NO_RESULT);
    add_row(REQ_KEY,  8'h79, 1'b1, 1, 1'b1, DONE_PLAIN);
    add_row(REQ_DATA, 8'h50, 1'b0, 1, 1'b0, NO_RESULT);
    add_row(REQ_DATA, 8'h6C, 1'b0, 1, 1'b0, NO_RESULT);
    add_row(REQ_DATA, 8'h61, 1'b0, 1, 1'b0, NO_RESULT);
    add_row(REQ_DATA, 8'h69, 1'b0, 1, 1'b0, NO_RESULT);
    add_row(REQ_DATA, 8'h6E, 1'b0, 1, 1'b0, NO_RESULT);
    // store filled with 0..255, one more byte overflows and is dropped
    add_row(REQ_KEY,  8'h00, 1'b0, KEY_DEPTH, 1'b0, NO_RESULT);
    add_row(REQ_KEY,  8'hAA, 1'b1, 1, 1'b1, DONE_CLIPPED);
    add_row(REQ_DATA, 8'h00, 1'b0, 1, 1'b0, NO_RESULT);
    // keys straight after a finished schedule; clipped flag must clear
    add_row(REQ_KEY,  8'h80, 1'b1, 1, 1'b1, DONE_PLAIN);
    add_row(REQ_KEY,  8'h01, 1'b1, 1, 1'b1, DONE_PLAIN);
    add_row(REQ_DATA, 8'hFF, 1'b0, 1, 1'b0, NO_RESULT);
    // exactly full store, not clipped
    add_row(REQ_KEY,  8'h01, 1'b0, KEY_DEPTH - 1, 1'b0, NO_RESULT);
    add_row(REQ_KEY,  8'hFF, 1'b1, 1, 1'b1, DONE_PLAIN);
    add_row(REQ_DATA, 8'h00, 1'b0, 1, 1'b0, NO_RESULT);

    foreach (directed_rows[i]) begin
      for (k = 0; k < directed_rows[i].reps; k++)
        send_item(directed_rows[i].req, directed_rows[i].value + k[BYTE_W-1:0],
                  directed_rows[i].last, directed_rows[i].fixed,
                  directed_rows[i].fixed_res);
    end

    // Random part: mostly full key loads followed by data bursts, plus
    // abandoned loads, bare data bursts and raw noise.
    stored_items = 0;
    while (stored_items < RANDOM_ITEMS) begin
      no_idle <= (stored_items >= 600 && stored_items < 900);
      pick = $urandom_range(99);
      if (pick < 78) begin
        r = $urandom_range(99);
        if (r < 85)      len = $urandom_range(16, 1);
        else if (r < 93) len = $urandom_range(64, 17);
        else if (r < 96) len = $urandom_range(KEY_DEPTH - 1, 65);
        else if (r < 98) len = KEY_DEPTH;
        else             len = $urandom_range(KEY_DEPTH + 6, KEY_DEPTH + 1);
        send_key(len, 1'b1);
        send_data($urandom_range(60, 1));
      end else if (pick < 88) begin
        send_key($urandom_range(6, 1), 1'b0);
        send_data($urandom_range(10, 1));
      end else if (pick < 94) begin
        send_data($urandom_range(20, 1));
      end else begin
        repeat ($urandom_range(8, 1)) begin
          send_item(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
                    1'($urandom_range(1)), 1'b0, NO_RESULT);
          stored_items++;
        end
      end
    end
    in_ch.valid <= 1'b0;
    no_idle     <= 1'b0;

    // drain, then give a trailing key byte time to show any stray result
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Scored %0d data results and %0d key schedules (%0d with clipped keys);",
             n_data, n_done, n_clipped);
    $display("%0d partial loads were abandoned by data, %0d mismatches seen.",
             n_abandoned, mismatches);
    if (mismatches == 0) begin
      $display("rc4_stream_cipher verification clean");
    end else begin
      $display("rc4_stream_cipher verification failed");
    end
    $finish;
  end

endmodule
